@@ hdl/deq_pkg.sv @@
// shared types and codes for the double-ended queue
package deq_pkg;

   // operation codes carried in the mode field
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_REVERSE    = 3'd4;
   localparam logic [2:0] MODE_PEEK       = 3'd5;

   // result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

   // input beat
   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] push_value;
   } req_type;

   // result beat
   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] front_value;
      logic [63:0] back_value;
      logic [4:0]  entry_count;
      logic        is_empty;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic fetch;
      logic load_rsp;
   } ctl_cmd_type;

endpackage

@@ hdl/deq_ctrl.sv @@
// sequencing controller for the double-ended queue
module deq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output deq_pkg::ctl_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_LOAD  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register can take a new beat
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid tracking
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/deq_dpath.sv @@
// ring storage, pointers and result register for the double-ended queue
module deq_dpath #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  deq_pkg::ctl_cmd_type cmd,
   input  deq_pkg::req_type     req_data,
   output deq_pkg::rsp_type     rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [SW-1:0] WRAP_SUM = SW'(DEPTH);

   // ring storage, no reset
   logic [VALUE_WIDTH-1:0] ring_ff [DEPTH];

   logic [2:0]             mode_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [AW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rev_ff, rev_in;
   logic [1:0]             status_ff, status_in;
   logic [VALUE_WIDTH-1:0] left_rd_ff, right_rd_ff;
   deq_pkg::rsp_type       rsp_ff;

   logic                   full, empty;
   logic [AW-1:0]          head_dec, head_inc;
   logic [SW-1:0]          tail_sum, last_sum;
   logic [AW-1:0]          tail_slot, last_slot;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] front_sel, back_sel;

   assign full  = (count_ff == FULL_COUNT);
   assign empty = (count_ff == '0);

   // neighbor slots of the left end
   assign head_dec = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;
   assign head_inc = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;

   // free slot past the right end
   assign tail_sum  = SW'(head_ff) + SW'(count_ff);
   assign tail_slot = (tail_sum >= WRAP_SUM) ? AW'(tail_sum - WRAP_SUM) : AW'(tail_sum);

   // occupied slot at the right end
   assign last_sum  = empty ? SW'(head_ff) : tail_sum - 1'b1;
   assign last_slot = (last_sum >= WRAP_SUM) ? AW'(last_sum - WRAP_SUM) : AW'(last_sum);

   // operation decode and pointer update
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      status_in = deq_pkg::STATUS_OK;
      wr_en     = 1'b0;
      wr_addr   = tail_slot;
      unique case (mode_ff) inside
         deq_pkg::MODE_PUSH_BACK, deq_pkg::MODE_PUSH_FRONT: begin
            if (full) begin
               status_in = deq_pkg::STATUS_PUSH_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if ((mode_ff == deq_pkg::MODE_PUSH_FRONT) != rev_ff) begin
                  wr_addr = head_dec;
                  head_in = head_dec;
               end
            end
         end
         deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
            if (empty) begin
               status_in = deq_pkg::STATUS_POP_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
               if ((mode_ff == deq_pkg::MODE_POP_FRONT) != rev_ff) begin
                  head_in = head_inc;
               end
            end
         end
         deq_pkg::MODE_REVERSE: begin
            rev_in = !rev_ff;
         end
         default: begin
         end
      endcase
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_data.mode;
         value_ff <= req_data.push_value[VALUE_WIDTH-1:0];
      end
   end

   // pointers, count and direction
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else if (cmd.execute) begin
         head_ff  <= head_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
      end
   end

   // ring write port
   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) begin
         ring_ff[wr_addr] <= value_ff;
      end
   end

   // ring read ports at both ends
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         left_rd_ff  <= ring_ff[head_ff];
         right_rd_ff <= ring_ff[last_slot];
      end
   end

   // front and back follow the direction bit
   assign front_sel = rev_ff ? right_rd_ff : left_rd_ff;
   assign back_sel  = rev_ff ? left_rd_ff : right_rd_ff;

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.front_value <= empty ? '0 : 64'(front_sel);
         rsp_ff.back_value  <= empty ? '0 : 64'(back_sel);
         rsp_ff.entry_count <= 5'(count_ff);
         rsp_ff.is_empty    <= empty;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ hdl/double_ended_queue_top.sv @@
// top level of the double-ended queue
//
//   channel   ports                               direction  beat
//   request   req_valid req_stall req_data        in         mode, push value
//   response  rsp_valid rsp_stall rsp_data        out        status, ends, count
//
// an item goes from accept to the next accept through capture, ring write and
// pointer update, registered two-port read of both ends, then result load.
// the ring read follows the write so that it sees the updated ring and pointers.
// reset clears the pointers, count, direction and result valid; ring contents stay.
// a stalled response holds in the output register while the next item is taken;
// that item waits at its load step until the register frees.
module double_ended_queue_top #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::rsp_type rsp_data
);

   deq_pkg::ctl_cmd_type cmd;

   // sequencing
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // storage and result
   deq_dpath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // one command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.execute, cmd.fetch, cmd.load_rsp}))
      else $error("more than one datapath command");

   // one item in flight: an accepted beat blocks the input next cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item is in flight");

   // an empty result reports zero count and zero ends
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |->
         rsp_data.entry_count == '0 && rsp_data.front_value == '0 &&
         rsp_data.back_value == '0)
      else $error("empty result with data");

   // a dropped push only happens with a non-empty ring
   a_full_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == deq_pkg::STATUS_PUSH_FULL |-> !rsp_data.is_empty)
      else $error("push dropped on empty ring");

endmodule

@@ dv/double_ended_queue_top_tb.sv @@
// testbench for the double-ended queue: directed and random beats checked against a shadow deque
module double_ended_queue_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 64;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 500;

   // mode codes the package leaves unnamed, treated as peek
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   deq_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   deq_pkg::rsp_type rsp_data;

   // shadow copy of the deque
   logic [VALUE_WIDTH-1:0] shadow_ring [DEPTH];
   logic [IDX_W-1:0]       shadow_head  = '0;
   logic [IDX_W:0]         shadow_count = '0;
   logic                   shadow_rev   = 1'b0;

   deq_pkg::rsp_type pending_views [$];

   int error_count   = 0;
   int sent_count    = 0;
   int checked_count = 0;
   int full_drops    = 0;
   int empty_pops    = 0;
   int cycle_count   = 0;
   int hold_left     = 0;
   bit hold_request  = 1'b0;
   bit steady_flow   = 1'b0;

   double_ended_queue_top #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // apply one operation to the shadow deque and return the view after it
   function automatic deq_pkg::rsp_type apply_op(deq_pkg::req_type op);
      deq_pkg::rsp_type view;
      logic             at_front;
      logic [IDX_W-1:0] tail_idx;
      logic [63:0]      left_word;
      logic [63:0]      right_word;
      view        = '0;
      view.status = deq_pkg::STATUS_OK;
      case (op.mode) inside
         deq_pkg::MODE_PUSH_BACK, deq_pkg::MODE_PUSH_FRONT: begin
            if (shadow_count == DEPTH) begin
               view.status = deq_pkg::STATUS_PUSH_FULL;
               full_drops++;
            end else begin
               at_front = (op.mode == deq_pkg::MODE_PUSH_FRONT);
               // front is the left end unless reversed
               if (at_front != shadow_rev) begin
                  shadow_head = shadow_head - 1'b1;
                  shadow_ring[shadow_head] = op.push_value[VALUE_WIDTH-1:0];
               end else begin
                  tail_idx = shadow_head + shadow_count[IDX_W-1:0];
                  shadow_ring[tail_idx] = op.push_value[VALUE_WIDTH-1:0];
               end
               shadow_count = shadow_count + 1'b1;
            end
         end
         deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
            if (shadow_count == 0) begin
               view.status = deq_pkg::STATUS_POP_EMPTY;
               empty_pops++;
            end else begin
               at_front = (op.mode == deq_pkg::MODE_POP_FRONT);
               if (at_front != shadow_rev) shadow_head = shadow_head + 1'b1;
               shadow_count = shadow_count - 1'b1;
            end
         end
         deq_pkg::MODE_REVERSE: shadow_rev = ~shadow_rev;
         default: ;
      endcase
      // both ends read zero when empty
      tail_idx = shadow_head + shadow_count[IDX_W-1:0] - 1'b1;
      if (shadow_count != 0) begin
         left_word        = shadow_ring[shadow_head];
         right_word       = shadow_ring[tail_idx];
         view.front_value = shadow_rev ? right_word : left_word;
         view.back_value  = shadow_rev ? left_word : right_word;
      end
      view.entry_count = shadow_count;
      view.is_empty    = (shadow_count == 0);
      return view;
   endfunction

   function automatic logic [63:0] random_word();
      case ($urandom_range(7))
         0:       return {64{1'b1}};
         1:       return 64'd0;
         2:       return 64'd1 << $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // random operation, push share in percent, rest mostly pops
   function automatic deq_pkg::req_type random_op(int unsigned push_pct);
      deq_pkg::req_type op;
      int unsigned      pick;
      pick = $urandom_range(99);
      if (pick < push_pct) begin
         op.mode = $urandom_range(1) ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_BACK;
      end else if (pick < 90) begin
         op.mode = $urandom_range(1) ? deq_pkg::MODE_POP_FRONT : deq_pkg::MODE_POP_BACK;
      end else if (pick < 95) begin
         op.mode = deq_pkg::MODE_REVERSE;
      end else if (pick < 98) begin
         op.mode = deq_pkg::MODE_PEEK;
      end else begin
         op.mode = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
      end
      op.push_value = random_word();
      return op;
   endfunction

   // offer one beat, with an optional gap first, and predict on accept
   task automatic send_beat(deq_pkg::req_type op);
      if (!steady_flow && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= op;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_views.push_back(apply_op(op));
      sent_count++;
   endtask

   task automatic send_op(logic [2:0] mode, logic [63:0] value);
      deq_pkg::req_type op;
      op.mode       = mode;
      op.push_value = value;
      send_beat(op);
   endtask

   // stop offering and wait for every expected view
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_views.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_cases();
      send_op(deq_pkg::MODE_POP_FRONT, random_word());
      send_op(deq_pkg::MODE_POP_BACK, random_word());
      send_op(deq_pkg::MODE_PEEK, random_word());
      send_op(deq_pkg::MODE_REVERSE, random_word());
      send_op(deq_pkg::MODE_PUSH_FRONT, {64{1'b1}});
      send_op(MODE_SPARE_LO, random_word());
      send_op(MODE_SPARE_HI, random_word());
   endtask

   // fill to the top, then push on full, reverse and pop both ends
   task automatic test_full_cases();
      logic [63:0] word;
      for (int i = 0; i < DEPTH - 1; i++) begin
         case (i)
            0:       word = 64'd0;
            1:       word = 64'h8000_0000_0000_0000;
            2:       word = 64'd1;
            3:       word = {64{1'b1}};
            default: word = random_word();
         endcase
         send_op(i[0] ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_BACK, word);
      end
      send_op(deq_pkg::MODE_PUSH_BACK, random_word());
      send_op(deq_pkg::MODE_PUSH_FRONT, random_word());
      send_op(deq_pkg::MODE_REVERSE, random_word());
      send_op(deq_pkg::MODE_POP_FRONT, random_word());
      send_op(deq_pkg::MODE_POP_BACK, random_word());
   endtask

   task automatic test_random_mix(int n, int unsigned push_pct);
      repeat (n) send_beat(random_op(push_pct));
   endtask

   // back-to-back beats on both sides
   task automatic test_steady_stream(int n);
      steady_flow = 1'b1;
      repeat (n) send_beat(random_op(45));
      wait_drained();
      steady_flow = 1'b0;
   endtask

   // receiver holds off while beats keep coming, so the input stalls
   task automatic test_receiver_holdoff(int n);
      hold_request = 1'b1;
      repeat (n) send_beat(random_op(50));
   endtask

   // sender stops until every view is back, then resumes
   task automatic test_sender_pause(int n);
      repeat (n) send_beat(random_op(50));
      wait_drained();
      repeat (n) send_beat(random_op(40));
   endtask

   // response stall: random, steady, or a long counted hold
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (steady_flow) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 31);
      end
   end

   // compare each response beat with the oldest expected view
   always @(posedge clock) begin
      deq_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_views.size() == 0) begin
            $display("%0t: unexpected response beat, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_views.pop_front();
            checked_count++;
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.front_value !== want.front_value) begin
               $display("%0t: front_value expected %h actual %h",
                        $time, want.front_value, rsp_data.front_value);
               error_count++;
            end
            if (rsp_data.back_value !== want.back_value) begin
               $display("%0t: back_value expected %h actual %h",
                        $time, want.back_value, rsp_data.back_value);
               error_count++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d",
                        $time, want.entry_count, rsp_data.entry_count);
               error_count++;
            end
            if (rsp_data.is_empty !== want.is_empty) begin
               $display("%0t: is_empty expected %0b actual %0b",
                        $time, want.is_empty, rsp_data.is_empty);
               error_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_cases();
      test_full_cases();
      test_random_mix(500, 60);
      test_random_mix(500, 30);
      test_receiver_holdoff(40);
      test_steady_stream(300);
      test_sender_pause(30);
      test_random_mix(600, 45);

      wait_drained();
      repeat (10) @(posedge clock);
      if (pending_views.size() != 0) begin
         $display("%0t: %0d expected views left over", $time, pending_views.size());
         error_count++;
      end

      $display("sent %0d beats, checked %0d responses, %0d full drops, %0d empty pops",
               sent_count, checked_count, full_drops, empty_pops);
      $display("covered empty and full ends, reversal, spare modes, long hold-off and pauses");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ double_ended_queue_top.f @@
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_dpath.sv
hdl/double_ended_queue_top.sv
dv/double_ended_queue_top_tb.sv
